### hdl/ebm_pkg.sv
// Shared types and constants for the extent block mapper.
`default_nettype none
package ebm_pkg;

  localparam int MAX_EXTENTS_DEF = 64;
  localparam int BLOCK_BITS_DEF  = 24;
  localparam int LENGTH_BITS_DEF = 8;

  localparam int COUNT_W      = 7;
  localparam int INDEX_W      = 6;
  localparam int BLOCK_CNT_W  = 16;
  localparam int RESULT_LIMIT = 64;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_CALC,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

### hdl/extent_block_mapper.sv
// Extent table and logical-to-disk block range translator.
//
// Load beats write one extent table entry. A translate beat is split into up to 64 disk
// runs; each run scans the extent table from entry 0 through a single read port, with a
// read state and then a subtract-and-compare state per entry examined, and then sizes
// and emits the run in a sizing state and an emit state. The block takes no new beat
// until the last result of a translate has been placed in the output register; that
// register lets the next beat in while the final result waits to be taken. A zero count
// or an empty table goes straight to the emit state and yields its single result.
`default_nettype none
module extent_block_mapper #(
  parameter int MAX_EXTENTS = ebm_pkg::MAX_EXTENTS_DEF,
  parameter int BLOCK_BITS  = ebm_pkg::BLOCK_BITS_DEF,
  parameter int LENGTH_BITS = ebm_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebm_pkg::COUNT_W-1:0]      cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic                             op,
  input  logic [ebm_pkg::INDEX_W-1:0]      entry_index,
  input  logic [BLOCK_BITS-1:0]            entry_file_block,
  input  logic [LENGTH_BITS-1:0]           entry_length,
  input  logic [BLOCK_BITS-1:0]            entry_disk_block,
  input  logic [BLOCK_BITS-1:0]            start_block,
  input  logic [ebm_pkg::BLOCK_CNT_W-1:0]  block_count,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [BLOCK_BITS-1:0]            disk_block,
  output logic [LENGTH_BITS-1:0]           run_length,
  output logic                             status,
  output logic                             last
);
  import ebm_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int LIM_W = $clog2(MAX_EXTENTS + 1);
  localparam int K_W   = $clog2(RESULT_LIMIT);
  localparam logic [K_W-1:0] K_MAX = K_W'(RESULT_LIMIT - 1);

  logic [BLOCK_BITS-1:0]  mem_start [MAX_EXTENTS];
  logic [LENGTH_BITS-1:0] mem_len   [MAX_EXTENTS];
  logic [BLOCK_BITS-1:0]  mem_disk  [MAX_EXTENTS];

  logic [BLOCK_BITS-1:0]  rd_start;
  logic [LENGTH_BITS-1:0] rd_len;
  logic [BLOCK_BITS-1:0]  rd_disk;

  state_t state, state_next;

  logic [COUNT_W-1:0]     extent_count;
  logic [BLOCK_BITS-1:0]  cur;
  logic [BLOCK_CNT_W-1:0] remaining;
  logic [IDX_W-1:0]       scan;
  logic [K_W-1:0]         res_count;
  logic [LENGTH_BITS-1:0] off;

  logic [BLOCK_BITS-1:0]  res_disk;
  logic [LENGTH_BITS-1:0] res_len;
  logic                   res_status;
  logic                   res_last;

  logic                   item_fire;
  logic                   load_fire;
  logic                   xlate_fire;
  logic                   emit_fire;
  logic [LIM_W-1:0]       limit;
  logic                   at_end;
  logic [BLOCK_BITS:0]    diff;
  logic                   hit;
  logic [LENGTH_BITS-1:0] avail;
  logic [LENGTH_BITS-1:0] run_n;
  logic [BLOCK_CNT_W-1:0] rem_next;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign load_fire  = item_fire && (op == OP_LOAD) && (32'(entry_index) < MAX_EXTENTS);
  assign xlate_fire = item_fire && (op == OP_TRANSLATE);
  assign emit_fire  = (state == S_EMIT) && (!result_valid || result_ready);

  assign limit  = (32'(extent_count) > MAX_EXTENTS) ? LIM_W'(MAX_EXTENTS)
                                                    : LIM_W'(extent_count);
  assign at_end = ({1'b0, LIM_W'(scan)} + 1'b1) >= {1'b0, limit};

  assign diff = {1'b0, cur} - {1'b0, rd_start};
  assign hit  = !diff[BLOCK_BITS] && (diff[BLOCK_BITS-1:0] < rd_len);

  assign avail    = rd_len - off;
  assign run_n    = (remaining < BLOCK_CNT_W'(avail)) ? LENGTH_BITS'(remaining) : avail;
  assign rem_next = remaining - BLOCK_CNT_W'(run_n);

  always_ff @(posedge clk) begin
    if (load_fire) begin
      mem_start[IDX_W'(entry_index)] <= entry_file_block;
      mem_len[IDX_W'(entry_index)]   <= entry_length;
      mem_disk[IDX_W'(entry_index)]  <= entry_disk_block;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      rd_start <= mem_start[scan];
      rd_len   <= mem_len[scan];
      rd_disk  <= mem_disk[scan];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (xlate_fire) begin
          if (block_count == '0 || limit == '0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (hit) begin
          state_next = S_CALC;
        end else if (at_end) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_CALC: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_next = res_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      extent_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (xlate_fire) begin
          cur        <= start_block;
          remaining  <= block_count;
          scan       <= '0;
          res_count  <= '0;
          res_disk   <= '0;
          res_len    <= '0;
          res_status <= (block_count != '0) ? STATUS_MISS : STATUS_OK;
          res_last   <= 1'b1;
        end
      end
      S_CHECK: begin
        if (hit) begin
          off <= LENGTH_BITS'(diff[BLOCK_BITS-1:0]);
        end else if (at_end) begin
          res_disk   <= '0;
          res_len    <= '0;
          res_status <= STATUS_MISS;
          res_last   <= 1'b1;
        end else begin
          scan <= scan + 1'b1;
        end
      end
      S_CALC: begin
        res_disk   <= rd_disk + BLOCK_BITS'(off);
        res_len    <= run_n;
        res_status <= STATUS_OK;
        res_last   <= (rem_next == '0) || (res_count == K_MAX);
        remaining  <= rem_next;
        cur        <= cur + BLOCK_BITS'(run_n);
      end
      S_EMIT: begin
        if (emit_fire && !res_last) begin
          res_count <= res_count + 1'b1;
          scan      <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      disk_block <= res_disk;
      run_length <= res_len;
      status     <= res_status;
      last       <= res_last;
    end
  end

  a_miss_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_MISS |-> last && run_length == '0 && disk_block == '0)
    else $error("uncovered block result is not a final empty run");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_length == '0 |-> last)
    else $error("empty run is not the final result");

  a_limit_last: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && res_count == K_MAX |-> res_last)
    else $error("result limit reached without last");

  a_offset_in_extent: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> off < rd_len && run_n != '0)
    else $error("run offset outside its extent");

  a_hit_sizes_run: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && hit |=> state == S_CALC)
    else $error("covering extent not sized");

endmodule
`default_nettype wire
